// File: src/ic0_preconditioner_3d_grid_unit_macros.svh
// ----------------------------------------------------------------------------
// IC(0) preconditioner assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef IC0_PRECONDITIONER_3D_GRID_UNIT_MACROS_SVH
`define IC0_PRECONDITIONER_3D_GRID_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define IC0_ASSERT_NOW(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> (cons)) else $error("ic0 assertion failed");

// consequent holds in the cycle after the antecedent
`define IC0_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error("ic0 assertion failed");

// consequent holds after a delay from the antecedent
`define IC0_ASSERT_LATER2(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> ##2 (cons)) else $error("ic0 assertion failed");

`endif

// File: src/ic0_pc_pkg.sv
// ----------------------------------------------------------------------------
// IC(0) preconditioner package
// Types, codes and fixed-point helpers shared by the preconditioner modules.
// ----------------------------------------------------------------------------
package ic0_pc_pkg;

    localparam int MAX_DIM     = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int SAT_BITS    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int IDX_FIELD_W = 12;
    localparam int CFG_W       = 5;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CNT_W       = $clog2(MAX_DIM);
    localparam int ACC_W       = DATA_W + 3;

    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;

    // opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] RS_LOAD  = 2'd0;
    localparam logic [1:0] RS_SOLVE = 2'd1;
    localparam logic [1:0] RS_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_X = 2'd0;
    localparam logic [1:0] CFG_GRID_Y = 2'd1;
    localparam logic [1:0] CFG_GRID_Z = 2'd2;

    // solve passes
    localparam logic [1:0] PH_PIV = 2'd0;
    localparam logic [1:0] PH_FWD = 2'd1;
    localparam logic [1:0] PH_BWD = 2'd2;

    // neighbour directions
    localparam logic [1:0] DIR_X = 2'd0;
    localparam logic [1:0] DIR_Y = 2'd1;
    localparam logic [1:0] DIR_Z = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [IDX_FIELD_W-1:0]   cell_index;
        logic                     is_fluid;
        logic signed [DATA_W-1:0] center_coeff;
        logic signed [DATA_W-1:0] right_coeff;
        logic signed [DATA_W-1:0] up_coeff;
        logic signed [DATA_W-1:0] front_coeff;
        logic signed [DATA_W-1:0] rhs_value;
    } ic0_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] solution_value;
    } ic0_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              load;
        logic              clr;
        logic              clr_all;
        logic [1:0]        phase;
        logic [1:0]        dir;
        logic              cap_self;
        logic              mul1;
        logic              rnd;
        logic              mul2;
        logic              acc_sub;
        logic              fin_mul;
        logic              div_start;
        logic              wr_res;
        logic              res_valid;
        logic [1:0]        res_status;
        logic              res_zero;
    } ic0_cmd_t;

    typedef struct packed {
        logic fluid;
        logic div_done;
    } ic0_stat_t;

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > VAL_MAX) r = VAL_MAX;
        else if (v < VAL_MIN) r = VAL_MIN;
        return r[DATA_W-1:0];
    endfunction

    // round to nearest, ties away from zero, drop the fraction, saturate
    function automatic logic signed [DATA_W-1:0] fround(input logic signed [63:0] p);
        logic               neg;
        logic [63:0]        m;
        logic signed [63:0] r;
        neg = p[63];
        m   = neg ? (64'd0 - 64'(p)) : 64'(p);
        m   = (m + 64'd32768) >> FRAC_W;
        r   = neg ? -$signed(m) : $signed(m);
        return sat64(r);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] d;
        d = v;
        if (d == '0) d = CFG_W'(1);
        if (int'(d) > MAX_DIM) d = CFG_W'(MAX_DIM);
        return DIM_W'(d);
    endfunction

endpackage

// File: src/ic0_preconditioner_3d_grid_unit.sv
// ----------------------------------------------------------------------------
// IC(0) preconditioner, 7-point 3D grid
// Loads cells, builds inverse pivots and applies forward/backward substitution.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every result appears
// for exactly one cycle with done high, and the receiver cannot stall it.
// After reset the unit runs a clearing pass over the fluid flags, pivots and
// work stores, with busy high; configuration writes are taken then too. A load
// (opcode 0) is acknowledged in the next cycle, and busy stays low so loads
// transfer one per cycle. A read (opcode 2) holds busy in a wait state for the
// registered memory read; its data shows after that read and the result
// register. A solve (opcode 1) clears the forward and solution stores, then
// walks the active grid three times through one shared multiplier: a non-fluid
// cell is skipped; a fluid cell in the pivot pass multiplies, rounds, scales by
// the neighbour pivot and rounds again per lower neighbour, then runs the
// bit-serial reciprocal; the substitution passes multiply, round and subtract
// per neighbour, then scale by the pivot. Opcode 3 is dropped with no result.
// ----------------------------------------------------------------------------
module ic0_preconditioner_3d_grid_unit
    import ic0_pc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ic0_in_t          request,
    output logic             done,
    output ic0_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ic0_cmd_t  cmd;
    ic0_stat_t stat;

    // sequencer: grid registers, walk counters, command generation
    ic0_pc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    // stores, arithmetic and the result register
    ic0_pc_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

// File: src/ic0_pc_recip.sv
// ----------------------------------------------------------------------------
// IC(0) reciprocal unit
// Restoring divider for 2^32/denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ic0_pc_recip
    import ic0_pc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] den,
    output logic                     done,
    output logic signed [DATA_W-1:0] recip
);

    localparam int NUM_W = DATA_W + 1;
    localparam int CT_W  = $clog2(NUM_W + 1);

    logic [CT_W-1:0]   cnt_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DATA_W-1:0] mag_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DATA_W-1:0] mag_in;
    logic [NUM_W-1:0]  rem_sh;
    logic              ge;
    logic signed [63:0] q_s;

    assign mag_in = den[DATA_W-1] ? (DATA_W'(0) - DATA_W'(den)) : DATA_W'(den);
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CT_W'(1));
            if (start)
                cnt_reg <= CT_W'(NUM_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= mag_in;
            neg_reg  <= den[DATA_W-1];
            zero_reg <= (den == '0);
            num_reg  <= {1'b1, DATA_W'(0)} + NUM_W'(mag_in >> 1);
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? DATA_W'(rem_sh - {1'b0, mag_reg}) : rem_sh[DATA_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign q_s   = $signed(64'(q_reg));
    assign done  = done_reg;
    assign recip = zero_reg ? '0 : sat64(neg_reg ? -q_s : q_s);

endmodule

// File: src/ic0_pc_dpath.sv
// ----------------------------------------------------------------------------
// IC(0) datapath
// Cell stores, shared multiplier with rounding, accumulator and result register.
// ----------------------------------------------------------------------------
module ic0_pc_dpath
    import ic0_pc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ic0_in_t   request,
    input  ic0_cmd_t  cmd,
    output ic0_stat_t stat,
    output logic      done,
    output ic0_out_t  result
);

    logic signed [DATA_W-1:0] center_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] right_mem  [STORE_DEPTH];
    logic signed [DATA_W-1:0] up_mem     [STORE_DEPTH];
    logic signed [DATA_W-1:0] front_mem  [STORE_DEPTH];
    logic signed [DATA_W-1:0] rhs_mem    [STORE_DEPTH];
    logic                     fluid_mem  [STORE_DEPTH];
    logic signed [DATA_W-1:0] piv_mem    [STORE_DEPTH];
    logic signed [DATA_W-1:0] fwd_mem    [STORE_DEPTH];
    logic signed [DATA_W-1:0] sol_mem    [STORE_DEPTH];

    logic signed [DATA_W-1:0] rd_center, rd_right, rd_up, rd_front, rd_rhs;
    logic signed [DATA_W-1:0] rd_piv, rd_fwd, rd_sol;
    logic                     rd_fluid;

    logic signed [DATA_W-1:0]   sf_right_reg, sf_up_reg, sf_front_reg, dself_reg, dnb_reg;
    logic signed [DATA_W-1:0]   rnd_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       done_reg;
    logic [1:0]                 status_reg;
    logic                       zero_reg;

    logic signed [DATA_W-1:0]   coef_nb, coef_sf, mul_a, mul_b, acc_sat, base, recip;
    logic signed [2*DATA_W-1:0] prod_w;
    logic                       div_done;

    ic0_pc_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .den   (acc_sat),
        .done  (div_done),
        .recip (recip)
    );

    // cell stores: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            center_mem[cmd.wr_addr] <= sat64(64'(request.center_coeff));
            right_mem[cmd.wr_addr]  <= sat64(64'(request.right_coeff));
            up_mem[cmd.wr_addr]     <= sat64(64'(request.up_coeff));
            front_mem[cmd.wr_addr]  <= sat64(64'(request.front_coeff));
            rhs_mem[cmd.wr_addr]    <= sat64(64'(request.rhs_value));
        end
        if (cmd.load || cmd.clr_all)
            fluid_mem[cmd.wr_addr] <= cmd.load & request.is_fluid;
        if (cmd.clr_all)
            piv_mem[cmd.wr_addr] <= '0;
        else if (cmd.wr_res && cmd.phase == PH_PIV)
            piv_mem[cmd.wr_addr] <= recip;
        if (cmd.clr)
            fwd_mem[cmd.wr_addr] <= '0;
        else if (cmd.wr_res && cmd.phase == PH_FWD)
            fwd_mem[cmd.wr_addr] <= rnd_reg;
        if (cmd.clr)
            sol_mem[cmd.wr_addr] <= '0;
        else if (cmd.wr_res && cmd.phase == PH_BWD)
            sol_mem[cmd.wr_addr] <= rnd_reg;

        rd_center <= center_mem[cmd.rd_addr];
        rd_right  <= right_mem[cmd.rd_addr];
        rd_up     <= up_mem[cmd.rd_addr];
        rd_front  <= front_mem[cmd.rd_addr];
        rd_rhs    <= rhs_mem[cmd.rd_addr];
        rd_fluid  <= fluid_mem[cmd.rd_addr];
        rd_piv    <= piv_mem[cmd.rd_addr];
        rd_fwd    <= fwd_mem[cmd.rd_addr];
        rd_sol    <= sol_mem[cmd.rd_addr];
    end

    assign acc_sat = sat64(64'(acc_reg));

    always_comb
    begin
        case (cmd.dir)
            DIR_X:   begin coef_nb = rd_right; coef_sf = sf_right_reg; end
            DIR_Y:   begin coef_nb = rd_up;    coef_sf = sf_up_reg;    end
            default: begin coef_nb = rd_front; coef_sf = sf_front_reg; end
        endcase

        case (cmd.phase)
            PH_PIV:  base = rd_center;
            PH_FWD:  base = rd_rhs;
            default: base = rd_fwd;
        endcase

        if (cmd.mul2)
        begin
            mul_a = rnd_reg;
            mul_b = dnb_reg;
        end
        else if (cmd.fin_mul)
        begin
            mul_a = acc_sat;
            mul_b = dself_reg;
        end
        else
        begin
            case (cmd.phase)
                PH_PIV:  begin mul_a = coef_nb; mul_b = coef_nb; end
                PH_FWD:  begin mul_a = coef_nb; mul_b = rd_fwd;  end
                default: begin mul_a = coef_sf; mul_b = rd_sol;  end
            endcase
        end
    end

    assign prod_w = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_self)
        begin
            acc_reg      <= ACC_W'(base);
            sf_right_reg <= rd_right;
            sf_up_reg    <= rd_up;
            sf_front_reg <= rd_front;
            dself_reg    <= rd_piv;
        end
        else if (cmd.acc_sub)
            acc_reg <= acc_reg - ACC_W'(rnd_reg);
        if (cmd.mul1 || cmd.mul2 || cmd.fin_mul)
            prod_reg <= prod_w;
        if (cmd.mul1)
            dnb_reg <= rd_piv;
        if (cmd.rnd)
            rnd_reg <= fround(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= RS_LOAD;
            zero_reg   <= 1'b1;
        end
        else
        begin
            done_reg <= cmd.res_valid;
            if (cmd.res_valid)
            begin
                status_reg <= cmd.res_status;
                zero_reg   <= cmd.res_zero || (cmd.res_status != RS_READ);
            end
        end
    end

    assign stat.fluid           = rd_fluid;
    assign stat.div_done        = div_done;
    assign done                 = done_reg;
    assign result.status        = status_reg;
    assign result.solution_value = zero_reg ? '0 : rd_sol;

endmodule

// File: src/ic0_pc_ctrl.sv
// ----------------------------------------------------------------------------
// IC(0) controller
// Grid registers, cell walk counters and the sequencer that drives the datapath.
// ----------------------------------------------------------------------------
module ic0_pc_ctrl
    import ic0_pc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ic0_in_t          request,
    output logic             busy,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  ic0_stat_t        stat,
    output ic0_cmd_t         cmd
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_INIT  = 4'd0;
    localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
    localparam logic [STATE_W-1:0] S_READ  = 4'd2;
    localparam logic [STATE_W-1:0] S_CLEAR = 4'd3;
    localparam logic [STATE_W-1:0] S_SELF  = 4'd4;
    localparam logic [STATE_W-1:0] S_SELFW = 4'd5;
    localparam logic [STATE_W-1:0] S_NB    = 4'd6;
    localparam logic [STATE_W-1:0] S_M1    = 4'd7;
    localparam logic [STATE_W-1:0] S_R1    = 4'd8;
    localparam logic [STATE_W-1:0] S_M2    = 4'd9;
    localparam logic [STATE_W-1:0] S_R2    = 4'd10;
    localparam logic [STATE_W-1:0] S_ACC   = 4'd11;
    localparam logic [STATE_W-1:0] S_FIN   = 4'd12;
    localparam logic [STATE_W-1:0] S_FRND  = 4'd13;
    localparam logic [STATE_W-1:0] S_DIV   = 4'd14;
    localparam logic [STATE_W-1:0] S_WR    = 4'd15;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [DIM_W-1:0]   gx_reg, gy_reg, gz_reg;
    logic [CNT_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [1:0]         dir_reg, dir_next, phase_reg, phase_next;
    logic               rdok_reg, rdok_next;

    logic [ADDR_W-1:0]  plane, nb_addr, idx_adv;
    logic [DIM_W-1:0]   i_w, j_w, k_w;
    logic [CNT_W-1:0]   i_adv, j_adv, k_adv;
    logic               bwd, nb_ok, last_cell, step_cell, accept, idx_ok;
    logic [ADDR_W-1:0]  in_addr;

    assign plane   = ADDR_W'(ADDR_W'(gx_reg) * ADDR_W'(gy_reg));
    assign i_w     = DIM_W'(i_reg);
    assign j_w     = DIM_W'(j_reg);
    assign k_w     = DIM_W'(k_reg);
    assign bwd     = (phase_reg == PH_BWD);
    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign idx_ok  = {1'b0, request.cell_index} < (IDX_FIELD_W + 1)'(STORE_DEPTH);
    assign in_addr = request.cell_index[ADDR_W-1:0];
    assign cfg_ready = 1'b1;

    // neighbour address and presence for the current direction
    always_comb
    begin
        case (dir_reg)
            DIR_X:
            begin
                nb_ok   = bwd ? (i_w + DIM_W'(1) < gx_reg) : (i_reg != '0);
                nb_addr = bwd ? idx_reg + ADDR_W'(1) : idx_reg - ADDR_W'(1);
            end
            DIR_Y:
            begin
                nb_ok   = bwd ? (j_w + DIM_W'(1) < gy_reg) : (j_reg != '0);
                nb_addr = bwd ? idx_reg + ADDR_W'(gx_reg) : idx_reg - ADDR_W'(gx_reg);
            end
            DIR_Z:
            begin
                nb_ok   = bwd ? (k_w + DIM_W'(1) < gz_reg) : (k_reg != '0);
                nb_addr = bwd ? idx_reg + plane : idx_reg - plane;
            end
            default:
            begin
                nb_ok   = 1'b0;
                nb_addr = idx_reg;
            end
        endcase
    end

    // next cell in walk order
    always_comb
    begin
        i_adv = i_reg;
        j_adv = j_reg;
        k_adv = k_reg;
        if (bwd)
        begin
            last_cell = (i_reg == '0) && (j_reg == '0) && (k_reg == '0);
            idx_adv   = idx_reg - ADDR_W'(1);
            if (i_reg == '0)
            begin
                i_adv = CNT_W'(gx_reg - DIM_W'(1));
                if (j_reg == '0)
                begin
                    j_adv = CNT_W'(gy_reg - DIM_W'(1));
                    k_adv = k_reg - CNT_W'(1);
                end
                else
                    j_adv = j_reg - CNT_W'(1);
            end
            else
                i_adv = i_reg - CNT_W'(1);
        end
        else
        begin
            last_cell = (i_w + DIM_W'(1) == gx_reg) && (j_w + DIM_W'(1) == gy_reg)
                        && (k_w + DIM_W'(1) == gz_reg);
            idx_adv   = idx_reg + ADDR_W'(1);
            if (i_w + DIM_W'(1) == gx_reg)
            begin
                i_adv = '0;
                if (j_w + DIM_W'(1) == gy_reg)
                begin
                    j_adv = '0;
                    k_adv = k_reg + CNT_W'(1);
                end
                else
                    j_adv = j_reg + CNT_W'(1);
            end
            else
                i_adv = i_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        dir_next   = dir_reg;
        phase_next = phase_reg;
        rdok_next  = rdok_reg;
        step_cell  = 1'b0;
        cmd        = '0;
        cmd.rd_addr = idx_reg;
        cmd.wr_addr = idx_reg;
        cmd.phase   = phase_reg;
        cmd.dir     = dir_reg;

        case (state_reg)
            S_INIT:
            begin
                cmd.clr     = 1'b1;
                cmd.clr_all = 1'b1;
                idx_next    = idx_reg + ADDR_W'(1);
                if (int'(idx_reg) == STORE_DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.rd_addr = in_addr;
                cmd.wr_addr = in_addr;
                if (accept)
                begin
                    case (request.opcode)
                        OP_LOAD:
                        begin
                            cmd.load       = idx_ok;
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = RS_LOAD;
                        end
                        OP_SOLVE:
                        begin
                            idx_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            // hold the read address so the result cycle sees it
                            idx_next   = in_addr;
                            rdok_next  = idx_ok;
                            state_next = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = RS_READ;
                cmd.res_zero   = !rdok_reg;
                state_next     = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clr  = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                if (int'(idx_reg) == STORE_DEPTH - 1)
                begin
                    idx_next   = '0;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    phase_next = PH_PIV;
                    state_next = S_SELF;
                end
            end
            S_SELF:
                state_next = S_SELFW;
            S_SELFW:
            begin
                cmd.cap_self = 1'b1;
                if (!stat.fluid)
                    step_cell = 1'b1;
                else
                begin
                    dir_next   = DIR_X;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                if (nb_ok)
                begin
                    cmd.rd_addr = nb_addr;
                    state_next  = S_M1;
                end
                else if (dir_reg == DIR_Z)
                    state_next = S_FIN;
                else
                    dir_next = dir_reg + 2'd1;
            end
            S_M1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_R1;
            end
            S_R1:
            begin
                cmd.rnd    = 1'b1;
                state_next = (phase_reg == PH_PIV) ? S_M2 : S_ACC;
            end
            S_M2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_R2;
            end
            S_R2:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_sub = 1'b1;
                if (dir_reg == DIR_Z)
                    state_next = S_FIN;
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NB;
                end
            end
            S_FIN:
            begin
                if (phase_reg == PH_PIV)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.fin_mul = 1'b1;
                    state_next  = S_FRND;
                end
            end
            S_FRND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_WR;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr_res = 1'b1;
                step_cell  = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase

        // advance the walk; at the end of a pass move to the next one
        if (step_cell)
        begin
            state_next = S_SELF;
            if (last_cell)
            begin
                case (phase_reg)
                    PH_PIV:
                    begin
                        phase_next = PH_FWD;
                        idx_next   = '0;
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                    end
                    PH_FWD:
                        phase_next = PH_BWD;
                    default:
                    begin
                        cmd.res_valid  = 1'b1;
                        cmd.res_status = RS_SOLVE;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            else
            begin
                i_next   = i_adv;
                j_next   = j_adv;
                k_next   = k_adv;
                idx_next = idx_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            gx_reg    <= clamp_dim(CFG_W'(MAX_DIM));
            gy_reg    <= clamp_dim(CFG_W'(MAX_DIM));
            gz_reg    <= clamp_dim(CFG_W'(MAX_DIM));
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            idx_reg   <= '0;
            dir_reg   <= DIR_X;
            phase_reg <= PH_PIV;
            rdok_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            dir_reg   <= dir_next;
            phase_reg <= phase_next;
            rdok_reg  <= rdok_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRID_X: gx_reg <= clamp_dim(cfg_data);
                    CFG_GRID_Y: gy_reg <= clamp_dim(cfg_data);
                    CFG_GRID_Z: gz_reg <= clamp_dim(cfg_data);
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: src/ic0_pc_checker.sv
// ----------------------------------------------------------------------------
// IC(0) port checker
// Watches the top-level ports for result timing per command.
// ----------------------------------------------------------------------------
`include "ic0_preconditioner_3d_grid_unit_macros.svh"

module ic0_pc_checker
    import ic0_pc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input ic0_in_t          request,
    input logic             done,
    input ic0_out_t         result
);

    `IC0_ASSERT_NEXT(a_load_ack, start && !busy && request.opcode == OP_LOAD, done && result.status == RS_LOAD)
    `IC0_ASSERT_NEXT(a_read_wait, start && !busy && request.opcode == OP_READ, busy && !done)
    `IC0_ASSERT_LATER2(a_read_data, start && !busy && request.opcode == OP_READ, done && result.status == RS_READ)
    `IC0_ASSERT_NOW(a_solve_idle, done && result.status == RS_SOLVE, !busy)
    `IC0_ASSERT_NEXT(a_drop_none, start && !busy && request.opcode == OP_NONE, !done)

endmodule

bind ic0_preconditioner_3d_grid_unit ic0_pc_checker u_ic0_pc_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IC(0) preconditioner unit testbench
// Streams load, solve and read commands into the 7-point IC(0) unit and checks
// every result against a built-in fixed-point solver. The run steps through a
// series of grid shapes, idles the command side in random bursts and checks
// that each status and solution word matches in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ic0_pc_pkg::*;

    localparam int CELLS       = 4096;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int PHASES      = 14;
    localparam int RAND_ITEMS  = 95;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    ic0_in_t          request = '0;
    logic             done;
    ic0_out_t         result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_GRID_X;
    logic [CFG_W-1:0] cfg_data = '0;

    ic0_preconditioner_3d_grid_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Commands waiting to be driven, and results the solver says must come back.
    ic0_in_t  pending_cmds[$];
    ic0_out_t expected_results[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;
    int gap_left = 0;

    // Active grid, shared by the stimulus and the solver (only changed when idle).
    int dim_x = 16;
    int dim_y = 16;
    int dim_z = 16;

    // Solver copy of the unit's stores.
    int center_mem[CELLS];
    int right_mem[CELLS];
    int up_mem[CELLS];
    int front_mem[CELLS];
    int rhs_mem[CELLS];
    bit fluid_mem[CELLS];
    int pivot_mem[CELLS];
    int forward_mem[CELLS];
    int solution_mem[CELLS];

    // Stimulus-side bookkeeping: which cells hold coefficients, which are fluid.
    bit cell_written[CELLS];
    bit cell_fluid[CELLS];

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point arithmetic of the solver
    // ------------------------------------------------------------------------
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, rounded half away from zero, saturated.
    function automatic longint qmul(longint a, longint b);
        longint p;
        longint m;
        bit     neg;
        p   = a * b;
        neg = (p < 0);
        m   = neg ? -p : p;
        m   = (m + 32768) >>> 16;
        return clip32(neg ? -m : m);
    endfunction

    // 1.0 / den in Q16.16; a zero denominator gives a zero pivot.
    function automatic longint qrecip(longint den);
        longint m;
        longint q;
        bit     neg;
        if (den == 0)
            return 0;
        neg = (den < 0);
        m   = neg ? -den : den;
        q   = ((64'sd1 <<< 32) + (m >>> 1)) / m;
        return clip32(neg ? -q : q);
    endfunction

    function automatic int grid_dim(int v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Solver: pivots, forward sweep, backward sweep
    // ------------------------------------------------------------------------
    function automatic void run_ic0_solve();
        int     plane;
        int     idx;
        longint acc;
        plane = dim_x * dim_y;
        for (int n = 0; n < CELLS; n++)
        begin
            forward_mem[n]  = 0;
            solution_mem[n] = 0;
        end
        for (int k = 0; k < dim_z; k++)
            for (int j = 0; j < dim_y; j++)
                for (int i = 0; i < dim_x; i++)
                begin
                    idx = i + j * dim_x + k * plane;
                    if (!fluid_mem[idx])
                        continue;
                    acc = center_mem[idx];
                    if (i > 0)
                        acc -= qmul(qmul(right_mem[idx-1], right_mem[idx-1]), pivot_mem[idx-1]);
                    if (j > 0)
                        acc -= qmul(qmul(up_mem[idx-dim_x], up_mem[idx-dim_x]),
                                    pivot_mem[idx-dim_x]);
                    if (k > 0)
                        acc -= qmul(qmul(front_mem[idx-plane], front_mem[idx-plane]),
                                    pivot_mem[idx-plane]);
                    pivot_mem[idx] = int'(qrecip(clip32(acc)));
                end
        for (int k = 0; k < dim_z; k++)
            for (int j = 0; j < dim_y; j++)
                for (int i = 0; i < dim_x; i++)
                begin
                    idx = i + j * dim_x + k * plane;
                    if (!fluid_mem[idx])
                        continue;
                    acc = rhs_mem[idx];
                    if (i > 0)
                        acc -= qmul(right_mem[idx-1], forward_mem[idx-1]);
                    if (j > 0)
                        acc -= qmul(up_mem[idx-dim_x], forward_mem[idx-dim_x]);
                    if (k > 0)
                        acc -= qmul(front_mem[idx-plane], forward_mem[idx-plane]);
                    forward_mem[idx] = int'(qmul(clip32(acc), pivot_mem[idx]));
                end
        for (int k = dim_z - 1; k >= 0; k--)
            for (int j = dim_y - 1; j >= 0; j--)
                for (int i = dim_x - 1; i >= 0; i--)
                begin
                    idx = i + j * dim_x + k * plane;
                    if (!fluid_mem[idx])
                        continue;
                    acc = forward_mem[idx];
                    if (i + 1 < dim_x)
                        acc -= qmul(right_mem[idx], solution_mem[idx+1]);
                    if (j + 1 < dim_y)
                        acc -= qmul(up_mem[idx], solution_mem[idx+dim_x]);
                    if (k + 1 < dim_z)
                        acc -= qmul(front_mem[idx], solution_mem[idx+plane]);
                    solution_mem[idx] = int'(qmul(clip32(acc), pivot_mem[idx]));
                end
    endfunction

    // Update the solver for one accepted command and queue what it must return.
    function automatic void apply_command(ic0_in_t cmd);
        ic0_out_t r;
        int       idx;
        idx = cmd.cell_index;
        r.solution_value = '0;
        case (cmd.opcode)
            OP_LOAD:
            begin
                fluid_mem[idx]  = cmd.is_fluid;
                center_mem[idx] = cmd.center_coeff;
                right_mem[idx]  = cmd.right_coeff;
                up_mem[idx]     = cmd.up_coeff;
                front_mem[idx]  = cmd.front_coeff;
                rhs_mem[idx]    = cmd.rhs_value;
                r.status = RS_LOAD;
                expected_results.push_back(r);
            end
            OP_SOLVE:
            begin
                run_ic0_solve();
                r.status = RS_SOLVE;
                expected_results.push_back(r);
            end
            OP_READ:
            begin
                r.status = RS_READ;
                r.solution_value = solution_mem[idx];
                expected_results.push_back(r);
            end
            default:
            begin
                // dropped by the unit, nothing comes back
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: hold start until the transfer, idle in random bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                apply_command(request);
            // hold the command while the unit is busy
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    request <= pending_cmds.pop_front();
                    start   <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 17);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every strobe must match the oldest expectation
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        ic0_out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(result), 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 64'(result.status), 64'(want.status));
                if (result.solution_value !== want.solution_value)
                    report_mismatch("solution_value", 64'(result.solution_value),
                                    64'(want.solution_value));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return 32'hffffffff;
                endcase
            end
            default: return $urandom_range(0, 32'h80000) - 32'h40000;
        endcase
    endfunction

    function automatic void push_load(int idx, bit fl, logic [31:0] c, logic [31:0] r,
                                      logic [31:0] u, logic [31:0] f, logic [31:0] b);
        ic0_in_t cmd;
        cmd.opcode       = OP_LOAD;
        cmd.cell_index   = IDX_FIELD_W'(idx);
        cmd.is_fluid     = fl;
        cmd.center_coeff = c;
        cmd.right_coeff  = r;
        cmd.up_coeff     = u;
        cmd.front_coeff  = f;
        cmd.rhs_value    = b;
        pending_cmds.push_back(cmd);
        cell_written[idx] = 1'b1;
        cell_fluid[idx]   = fl;
    endfunction

    // Mostly diagonally dominant cells (positive center, small negative
    // couplings) so the sweeps carry real values; the rest is raw noise.
    function automatic void push_random_load(int idx, bit fl);
        if ($urandom_range(0, 9) < 7)
            push_load(idx, fl, $urandom_range(32'h20000, 32'h80000),
                      -$urandom_range(0, 32'h10000), -$urandom_range(0, 32'h10000),
                      -$urandom_range(0, 32'h10000), any_word());
        else
            push_load(idx, fl, any_word(), any_word(), any_word(), any_word(), any_word());
    endfunction

    function automatic void push_simple(logic [1:0] op, int idx);
        ic0_in_t cmd;
        cmd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        cmd.opcode     = op;
        cmd.cell_index = IDX_FIELD_W'(idx);
        pending_cmds.push_back(cmd);
    endfunction

    // Load any cell a solve would read before it was ever written, then solve.
    function automatic void push_solve();
        int plane;
        int idx;
        plane = dim_x * dim_y;
        for (int k = 0; k < dim_z; k++)
            for (int j = 0; j < dim_y; j++)
                for (int i = 0; i < dim_x; i++)
                begin
                    idx = i + j * dim_x + k * plane;
                    if (!cell_fluid[idx])
                        continue;
                    if (i > 0 && !cell_written[idx-1])
                        push_random_load(idx - 1, 1'b0);
                    if (j > 0 && !cell_written[idx-dim_x])
                        push_random_load(idx - dim_x, 1'b0);
                    if (k > 0 && !cell_written[idx-plane])
                        push_random_load(idx - plane, 1'b0);
                end
        push_simple(OP_SOLVE, 0);
    endfunction

    function automatic int grid_cell();
        return $urandom_range(0, dim_x * dim_y * dim_z - 1);
    endfunction

    // Wait until every command has transferred and every result came back,
    // then let the unit settle after a dropped command.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0 ||
               gap_left != 0 || busy);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_grid_reg(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_X: dim_x = grid_dim(value);
            CFG_GRID_Y: dim_y = grid_dim(value);
            default:    dim_z = grid_dim(value);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    int grid_plan[PHASES][3] = '{
        '{1, 1, 1}, '{16, 1, 1}, '{1, 16, 1}, '{1, 1, 16}, '{0, 31, 2},
        '{3, 3, 3}, '{4, 2, 3}, '{2, 5, 2}, '{31, 0, 4}, '{5, 4, 3},
        '{2, 2, 2}, '{8, 2, 1}, '{3, 4, 4}, '{4, 4, 4}
    };

    int read_cells[9] = '{0, 1, 2, 3, 16, 17, 256, 4095, 100};

    initial
    begin
        int sel;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the full 16x16x16 reset grid with a few fluid cells:
        // saturating extremes, a zero pivot denominator, all three neighbours.
        push_load(0, 1, 32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'h7fffffff);
        push_load(1, 1, 32'h00010000, 32'h0, 32'hffff0000, 32'h80000000, 32'h80000000);
        push_load(2, 1, 32'h0, 32'hffffc000, 32'h7fffffff, 32'h0, 32'h00030000);
        push_load(3, 0, 32'h00020000, 32'h00008000, 32'h1, 32'hffffffff, 32'h1);
        push_load(16, 1, 32'h00040000, 32'hffff0000, 32'hffff0000, 32'hffff0000,
                  32'h00010000);
        push_load(17, 1, 32'h00050000, 32'hffff8000, 32'h00007fff, 32'hffff0001,
                  32'hfffe0000);
        push_load(256, 1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h00010000);
        push_load(4095, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'hffffffff);
        push_solve();
        foreach (read_cells[n])
            push_simple(OP_READ, read_cells[n]);
        push_simple(OP_NONE, 5);
        push_load(0, 0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_solve();
        push_simple(OP_READ, 1);
        push_simple(OP_READ, 16);
        wait_drained();

        // Random part: one phase per grid shape, no idling in the last phases.
        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p >= PHASES - 2);
            write_grid_reg(CFG_GRID_X, grid_plan[p][0]);
            write_grid_reg(CFG_GRID_Y, grid_plan[p][1]);
            write_grid_reg(CFG_GRID_Z, grid_plan[p][2]);
            for (int n = 0; n < dim_x * dim_y * dim_z; n++)
                push_random_load(n, $urandom_range(0, 3) != 0);
            push_solve();
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    push_random_load(($urandom_range(0, 9) < 7) ? grid_cell()
                                     : $urandom_range(0, CELLS - 1),
                                     $urandom_range(0, 1) != 0);
                else if (sel < 94)
                    push_simple(OP_READ, ($urandom_range(0, 9) < 7) ? grid_cell()
                                : $urandom_range(0, CELLS - 1));
                else if (sel < 97)
                    push_solve();
                else
                    push_simple(OP_NONE, $urandom_range(0, CELLS - 1));
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
